### hw/rtl/peer_liveness_registry_defines.svh
// Assertion macros for the peer liveness registry RTL, included by the controller.
`ifndef PEER_LIVENESS_REGISTRY_DEFINES_SVH
`define PEER_LIVENESS_REGISTRY_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PLR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hw/rtl/plr_pkg.sv
// Types and constants for the peer liveness registry.
package plr_pkg;

    localparam logic [1:0] FUNC_HEARTBEAT = 2'd0;
    localparam logic [1:0] FUNC_APPROVE   = 2'd1;
    localparam logic [1:0] FUNC_REFRESH   = 2'd2;

    localparam logic [1:0] KIND_HB_ACK    = 2'd0;
    localparam logic [1:0] KIND_APPROVE   = 2'd1;
    localparam logic [1:0] KIND_PROBE     = 2'd2;
    localparam logic [1:0] KIND_DONE      = 2'd3;

    localparam logic [1:0] PH_HEARD    = 2'd0;
    localparam logic [1:0] PH_SENT     = 2'd1;
    localparam logic [1:0] PH_APPROVED = 2'd2;
    localparam logic [1:0] PH_DENIED   = 2'd3;

    localparam logic [1:0] CFG_PEER_EXPIRY    = 2'd0;
    localparam logic [1:0] CFG_STATUS_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_MAX_RESENDS    = 2'd2;
    localparam logic [1:0] CFG_PROBE_GAP      = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] ip_addr;
        logic [15:0] port;
        logic [31:0] now;
    } plr_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic        ok;
        logic [5:0]  visible_count;
        logic [5:0]  pending_count;
        logic        last;
    } plr_out_t;

    // One table entry apart from its valid bit.
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [1:0]  phase;
        logic        shown;
        logic [31:0] hb_time;
        logic [31:0] acc_time;
        logic [31:0] probe_time;
        logic [7:0]  probe_count;
    } plr_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_RD, ST_SCAN_EV, ST_HB_END, ST_AP_END,
        ST_RF_RD, ST_RF_EV, ST_RF_EMIT, ST_RF_DONE, ST_OUT
    } plr_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic clr_idx;
        logic inc_idx;
        logic rd;
        logic rd_match;
        logic scan_eval;
        logic hb_write;
        logic ap_write;
        logic rf_eval;
        logic rf_probe;
        logic ld_probe_out;
        logic ld_ack_out;
        logic ld_done_out;
    } plr_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic last_idx;
        logic match_found;
        logic want_probe;
    } plr_sts_t;

endpackage

### hw/rtl/plr_datapath.sv
// Datapath: peer table memory, slot walker, match, refresh checks and result register.
module plr_datapath import plr_pkg::*; #(
    parameter int TABLE_SLOTS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  plr_cmd_t   cmd,
    output plr_sts_t   sts,
    input  plr_in_t    req,
    input  logic [31:0] peer_expiry,
    input  logic [31:0] status_timeout,
    input  logic [7:0]  max_resends,
    input  logic [31:0] probe_gap,
    output plr_out_t   res
);
    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    plr_entry_t mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [IW-1:0] idx_reg;
    plr_entry_t rd_reg;
    logic match_reg, match_next;
    logic [IW-1:0] match_idx_reg, free_idx_reg;
    logic free_found_reg;
    logic probe_reg;
    logic [5:0] vis_reg, pend_reg;
    plr_out_t res_reg, res_next;

    logic cur_valid;
    logic [31:0] srv_dl, stat_dl;
    logic drop_c, probe_c;
    plr_entry_t wr_e;
    logic [IW-1:0] wr_idx;
    logic wr_en;
    logic [IW-1:0] rd_idx;

    assign cur_valid = valid_reg[idx_reg];
    assign srv_dl = req.now - peer_expiry;
    assign stat_dl = req.now - status_timeout;

    // Refresh decisions for the entry just read.
    always_comb
    begin
        drop_c = 1'b0;
        probe_c = 1'b0;
        if (rd_reg.phase == PH_APPROVED && rd_reg.acc_time < srv_dl)
            drop_c = 1'b1;
        else if (rd_reg.phase == PH_SENT &&
                 (rd_reg.hb_time < stat_dl || rd_reg.probe_count >= max_resends))
            drop_c = 1'b1;
        else if ((rd_reg.phase == PH_SENT &&
                  32'(rd_reg.probe_time + probe_gap) < req.now) ||
                 rd_reg.phase == PH_HEARD)
            probe_c = 1'b1;
    end

    assign match_next = cur_valid && rd_reg.addr == req.ip_addr && rd_reg.port == req.port;

    // Table write selection.
    always_comb
    begin
        wr_en = 1'b0;
        wr_idx = idx_reg;
        wr_e = rd_reg;
        if (cmd.hb_write)
        begin
            if (match_reg)
            begin
                wr_en = 1'b1;
                wr_idx = match_idx_reg;
                wr_e = rd_reg;
                wr_e.hb_time = req.now;
                wr_e.phase = PH_HEARD;
            end
            else if (free_found_reg)
            begin
                wr_en = 1'b1;
                wr_idx = free_idx_reg;
                wr_e.addr = req.ip_addr;
                wr_e.port = req.port;
                wr_e.phase = PH_HEARD;
                wr_e.shown = 1'b0;
                wr_e.hb_time = req.now;
                wr_e.acc_time = '0;
                wr_e.probe_time = '0;
                wr_e.probe_count = '0;
            end
        end
        else if (cmd.ap_write && match_reg && rd_reg.phase != PH_DENIED)
        begin
            wr_en = 1'b1;
            wr_idx = match_idx_reg;
            wr_e = rd_reg;
            wr_e.acc_time = req.now;
            wr_e.phase = PH_APPROVED;
            wr_e.probe_count = '0;
            wr_e.shown = 1'b1;
        end
        else if (cmd.rf_probe)
        begin
            wr_en = 1'b1;
            wr_e = rd_reg;
            wr_e.probe_time = req.now;
            wr_e.probe_count = rd_reg.probe_count + 8'd1;
            wr_e.phase = PH_SENT;
        end
    end

    // Read address: slot 0 when a request is taken, the matched slot after a scan.
    assign rd_idx = cmd.clr_idx ? '0 : (cmd.rd_match ? match_idx_reg : idx_reg);

    // Table memory: one read port, one write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_e;
        if (cmd.rd)
            rd_reg <= mem[rd_idx];
    end

    // Valid bits, walker and scan results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            idx_reg <= '0;
            match_reg <= 1'b0;
            match_idx_reg <= '0;
            free_idx_reg <= '0;
            free_found_reg <= 1'b0;
            probe_reg <= 1'b0;
            vis_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (cmd.clr_idx)
            begin
                idx_reg <= '0;
                match_reg <= 1'b0;
                free_found_reg <= 1'b0;
                vis_reg <= '0;
                pend_reg <= '0;
            end
            else if (cmd.inc_idx)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.scan_eval)
            begin
                if (match_next && !match_reg)
                begin
                    match_reg <= 1'b1;
                    match_idx_reg <= idx_reg;
                end
                if (!cur_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
            end
            if (cmd.hb_write && !match_reg && free_found_reg)
                valid_reg[free_idx_reg] <= 1'b1;
            if (cmd.rf_eval)
            begin
                probe_reg <= cur_valid && !drop_c && probe_c;
                if (cur_valid && drop_c)
                    valid_reg[idx_reg] <= 1'b0;
                else if (cur_valid)
                begin
                    if (!rd_reg.shown)
                        pend_reg <= pend_reg + 6'd1;
                    else
                        vis_reg <= vis_reg + 6'd1;
                end
            end
        end
    end

    // Next result word.
    always_comb
    begin
        res_next = '0;
        if (cmd.ld_probe_out)
        begin
            res_next.kind = KIND_PROBE;
            res_next.peer_addr = rd_reg.addr;
            res_next.peer_port = rd_reg.port;
        end
        else if (cmd.ld_ack_out)
        begin
            res_next.kind = (req.func == FUNC_HEARTBEAT) ? KIND_HB_ACK : KIND_APPROVE;
            res_next.peer_addr = req.ip_addr;
            res_next.peer_port = req.port;
            res_next.ok = (req.func == FUNC_HEARTBEAT) ? (match_reg || free_found_reg)
                                                       : (match_reg && rd_reg.phase != PH_DENIED);
            res_next.last = 1'b1;
        end
        else if (cmd.ld_done_out)
        begin
            res_next.kind = KIND_DONE;
            res_next.peer_addr = req.ip_addr;
            res_next.peer_port = req.port;
            res_next.visible_count = vis_reg;
            res_next.pending_count = pend_reg;
            res_next.last = 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_probe_out || cmd.ld_ack_out || cmd.ld_done_out)
            res_reg <= res_next;
    end

    assign res = res_reg;
    assign sts.last_idx = (idx_reg == IW'(TABLE_SLOTS - 1));
    assign sts.match_found = match_reg;
    assign sts.want_probe = probe_reg;
endmodule

### hw/rtl/plr_ctrl.sv
// Controller state machine sequencing table scans and result delivery.
`include "peer_liveness_registry_defines.svh"
module plr_ctrl import plr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] func,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  logic       out_last,
    input  plr_sts_t   sts,
    output plr_cmd_t   cmd
);
    plr_state_t state_reg, state_next;
    plr_state_t ret_reg, ret_next;
    logic [1:0] func_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg <= ST_IDLE;
            func_reg <= FUNC_HEARTBEAT;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            if (state_reg == ST_IDLE && in_valid)
                func_reg <= func;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.clr_idx = 1'b1;
                if (in_valid)
                begin
                    cmd.rd = 1'b1;
                    if (func == FUNC_REFRESH)
                        state_next = ST_RF_EV;
                    else if (func == FUNC_HEARTBEAT || func == FUNC_APPROVE)
                        state_next = ST_SCAN_EV;
                end
            end
            ST_SCAN_RD:
            begin
                cmd.rd = 1'b1;
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
                if (sts.last_idx)
                    state_next = ST_HB_END;
                else
                begin
                    cmd.inc_idx = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_HB_END:
            begin
                // Read the matched entry, then write and acknowledge.
                cmd.rd = sts.match_found;
                cmd.rd_match = 1'b1;
                state_next = ST_AP_END;
            end
            ST_AP_END:
            begin
                if (func_reg == FUNC_HEARTBEAT)
                    cmd.hb_write = 1'b1;
                else
                    cmd.ap_write = 1'b1;
                cmd.ld_ack_out = 1'b1;
                ret_next = ST_IDLE;
                state_next = ST_OUT;
            end
            ST_RF_RD:
            begin
                cmd.rd = 1'b1;
                state_next = ST_RF_EV;
            end
            ST_RF_EV:
            begin
                cmd.rf_eval = 1'b1;
                state_next = ST_RF_EMIT;
            end
            ST_RF_EMIT:
            begin
                if (sts.want_probe)
                begin
                    cmd.rf_probe = 1'b1;
                    cmd.ld_probe_out = 1'b1;
                    ret_next = ST_RF_DONE;
                    state_next = ST_OUT;
                end
                else
                    state_next = ST_RF_DONE;
            end
            ST_RF_DONE:
            begin
                if (sts.last_idx)
                begin
                    cmd.ld_done_out = 1'b1;
                    ret_next = ST_IDLE;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                    state_next = ST_RF_RD;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ret_reg;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `PLR_ASSERT_IMPL(a_no_accept_busy, state_reg != ST_IDLE, in_stall, "accept while busy")
    `PLR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")
    `PLR_ASSERT_IMPL(a_last_idle, out_valid && !out_stall && out_last, ret_reg == ST_IDLE,
        "last flag mismatch")
endmodule

### hw/rtl/peer_liveness_registry.sv
// Peer liveness registry: a table of TABLE_SLOTS peers walked one slot per step.
// Heartbeat and approve: every slot is read and compared, then the matched entry is read,
//   written and acknowledged; the next accept waits until the result leaves the output.
// Refresh: every slot is read and checked, with a probe result per peer due a probe, then a done result.
// One request is in work at a time; results leave through a registered output.
// Reset clears all valid bits at once and loads the register defaults; no clearing pass.
module peer_liveness_registry import plr_pkg::*; #(
    parameter int TABLE_SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  plr_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output plr_out_t    out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [31:0] peer_expiry_reg, status_timeout_reg, probe_gap_reg;
    logic [7:0] max_resends_reg;
    plr_in_t req_reg;
    plr_cmd_t cmd;
    plr_sts_t sts;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_expiry_reg <= 32'd300000;
            status_timeout_reg <= 32'd30000;
            max_resends_reg <= 8'd5;
            probe_gap_reg <= 32'd5000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PEER_EXPIRY: peer_expiry_reg <= cfg_data;
                CFG_STATUS_TIMEOUT: status_timeout_reg <= cfg_data;
                CFG_MAX_RESENDS: max_resends_reg <= cfg_data[7:0];
                CFG_PROBE_GAP: probe_gap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            req_reg <= in_data;
    end

    plr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .func(in_data.func),
        .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
        .out_last(out_data.last), .sts(sts), .cmd(cmd)
    );

    plr_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .req(req_reg),
        .peer_expiry(peer_expiry_reg), .status_timeout(status_timeout_reg),
        .max_resends(max_resends_reg), .probe_gap(probe_gap_reg),
        .res(out_data)
    );
endmodule
